// File: rtl/core/u8d_pkg.sv
// Shared types and constants for the UTF-8 byte stream decoder.
package u8d_pkg;

    localparam int CP_W = 22;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_BASE  = 8'hC0;
    localparam logic [7:0] LEAD3_BASE  = 8'hE0;
    localparam logic [7:0] LEAD4_BASE  = 8'hF0;
    localparam logic [6:0] QMARK       = 7'h3F;

    typedef logic [1:0] t_kind;
    localparam t_kind OP_EMIT = 2'd0;
    localparam t_kind OP_LEAD = 2'd1;
    localparam t_kind OP_CONT = 2'd2;

    // One classified byte handed from the front to the back.
    typedef struct packed {
        t_kind      kind;
        logic       last;
        logic       rep;
        logic [6:0] bits;
    } t_op;

endpackage

// File: rtl/core/u8d_front.sv
// Front part: accepts raw bytes, tracks sequence position and classifies each byte.
module u8d_front
    import u8d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_byte_in,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_q_ready,
    output logic       o_q_push,
    output t_op        o_q_op
);

    logic [1:0] r_pending;
    logic [1:0] n_pending;
    logic       accept;
    logic       push;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;
    assign o_q_push   = accept && push;

    always_comb begin
        n_pending = r_pending;
        push      = 1'b1;
        o_q_op    = '{kind: OP_EMIT, last: 1'b0, rep: 1'b0, bits: 7'd0};
        if (r_pending != 2'd0) begin
            o_q_op.kind = OP_CONT;
            o_q_op.last = (r_pending == 2'd1);
            o_q_op.bits = {1'b0, i_byte_in[5:0]};
            n_pending   = r_pending - 2'd1;
        end else if (i_byte_in == 8'd0) begin
            // End of string marker: nothing goes to the back.
            push = 1'b0;
        end else if (i_byte_in < ASCII_LIMIT) begin
            o_q_op.bits = i_byte_in[6:0];
        end else if (i_byte_in < LEAD2_BASE) begin
            o_q_op.rep  = 1'b1;
            o_q_op.bits = QMARK;
        end else if (i_byte_in < LEAD3_BASE) begin
            o_q_op.kind = OP_LEAD;
            o_q_op.bits = {2'b00, i_byte_in[4:0]};
            n_pending   = 2'd1;
        end else if (i_byte_in < LEAD4_BASE) begin
            o_q_op.kind = OP_LEAD;
            o_q_op.bits = {3'b000, i_byte_in[3:0]};
            n_pending   = 2'd2;
        end else begin
            o_q_op.kind = OP_LEAD;
            o_q_op.bits = {3'b000, i_byte_in[3:0]};
            n_pending   = 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
        end else if (accept) begin
            r_pending <= n_pending;
        end
    end

endmodule

// File: rtl/core/u8d_queue.sv
// Short queue of classified words between the front and the back.
module u8d_queue
    import u8d_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_ready,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_pop
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/core/u8d_back.sv
// Back part: gathers code point bits and holds the result in an output register.
module u8d_back
    import u8d_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  t_op             i_q_op,
    output logic            o_q_pop,
    output logic [CP_W-1:0] o_code_point,
    output logic            o_replaced,
    output logic            o_out_valid,
    input  logic            i_out_ready
);

    logic [CP_W-1:0] r_partial;
    logic [CP_W-1:0] n_partial;
    logic [CP_W-1:0] r_code_point;
    logic            r_replaced;
    logic            r_out_valid;
    logic            out_free;
    logic            emits;

    assign out_free = !r_out_valid || i_out_ready;
    assign emits    = (i_q_op.kind == OP_EMIT) || ((i_q_op.kind == OP_CONT) && i_q_op.last);
    assign o_q_pop  = i_q_valid && (!emits || out_free);

    always_comb begin
        unique case (i_q_op.kind)
            OP_LEAD: n_partial = {{(CP_W - 7){1'b0}}, i_q_op.bits};
            OP_CONT: n_partial = {r_partial[CP_W-7:0], i_q_op.bits[5:0]};
            default: n_partial = r_partial;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_partial <= n_partial;
        end
        if (o_q_pop && emits) begin
            if (i_q_op.kind == OP_EMIT) begin
                r_code_point <= {{(CP_W - 7){1'b0}}, i_q_op.bits};
            end else begin
                r_code_point <= n_partial;
            end
            r_replaced <= i_q_op.rep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_q_pop && emits;
        end
    end

    assign o_code_point = r_code_point;
    assign o_replaced   = r_replaced;
    assign o_out_valid  = r_out_valid;

endmodule

// File: rtl/core/utf8_byte_stream_decoder_top.sv
// Top level of the lenient UTF-8 byte stream decoder.
//
// Input channel: one raw byte per word on i_byte_in, handshake i_in_valid and
// o_in_ready. Output channel: one decoded character per word on o_code_point
// and o_replaced, handshake o_out_valid and i_out_ready.
// ASCII bytes give their own value; lead bytes start two to four byte
// sequences whose following bytes each add their low six bits; a stray
// continuation byte as a lead gives '?' with o_replaced set; a zero lead byte
// ends a string and gives no word.
// Throughput is one byte per cycle while the queue has room. A result passes
// from the two-entry queue behind the classifying front into the output
// register of the back, which holds it.
// Reset (synchronous, active low) empties the queue and the output register
// and returns the decoder to expecting a lead byte.
// When the receiver stalls, the output register holds its word, the queue
// fills, and o_in_ready falls once both queue entries are taken.
module utf8_byte_stream_decoder_top
    import u8d_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_byte_in,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic [CP_W-1:0] o_code_point,
    output logic            o_replaced,
    output logic            o_out_valid,
    input  logic            i_out_ready
);

    logic q_ready;
    logic q_push;
    t_op  q_in_op;
    logic q_valid;
    t_op  q_out_op;
    logic q_pop;

    u8d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_in  (i_byte_in),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_op     (q_in_op)
    );

    u8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (q_out_op),
        .i_pop   (q_pop)
    );

    u8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_op       (q_out_op),
        .o_q_pop      (q_pop),
        .o_code_point (o_code_point),
        .o_replaced   (o_replaced),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready)
    );

endmodule

// File: tb/utf8_byte_stream_decoder_checker.sv
// Checker for the UTF-8 byte stream decoder: predicts every output word and compares it.
module utf8_byte_stream_decoder_checker
    import u8d_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_byte_in,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  logic [CP_W-1:0] i_code_point,
    input  logic            i_replaced,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    output int              o_fail_count,
    output int              o_pending
);

    localparam logic [7:0] END_MARK = 8'h00;

    typedef struct {
        logic [CP_W-1:0] code_point;
        logic            replaced;
    } char_word_t;

    char_word_t      chars_expected[$];
    logic [1:0]      follow_left;
    logic [CP_W-1:0] cp_accum;
    int              mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
        follow_left  = '0;
        cp_accum     = '0;
    end

    task automatic push_char(input logic [CP_W-1:0] cp, input logic rep);
        char_word_t w;
        w.code_point = cp;
        w.replaced   = rep;
        chars_expected.push_back(w);
    endtask

    // Advances the decoder state by one byte and queues the character it completes.
    task automatic decode_byte(input logic [7:0] b);
        if (follow_left != 2'd0) begin
            // Any byte in a following position adds its low six bits, unchecked.
            cp_accum    = {cp_accum[CP_W-7:0], b[5:0]};
            follow_left = follow_left - 2'd1;
            if (follow_left == 2'd0)
                push_char(cp_accum, 1'b0);
        end else if (b == END_MARK) begin
            // The end of a string gives no word.
        end else if (b < ASCII_LIMIT) begin
            push_char(CP_W'(b), 1'b0);
        end else if (b < LEAD2_BASE) begin
            push_char(CP_W'(QMARK), 1'b1);
        end else if (b < LEAD3_BASE) begin
            cp_accum    = CP_W'(b - LEAD2_BASE);
            follow_left = 2'd1;
        end else if (b < LEAD4_BASE) begin
            cp_accum    = CP_W'(b - LEAD3_BASE);
            follow_left = 2'd2;
        end else begin
            cp_accum    = CP_W'(b - LEAD4_BASE);
            follow_left = 2'd3;
        end
    endtask

    task automatic check_char();
        char_word_t w;
        if (chars_expected.size() == 0) begin
            $error("unexpected word: code_point %h replaced %b", i_code_point, i_replaced);
            mismatches++;
        end else begin
            w = chars_expected.pop_front();
            if (i_code_point !== w.code_point) begin
                $error("code_point mismatch: expected %h, got %h", w.code_point, i_code_point);
                mismatches++;
            end
            if (i_replaced !== w.replaced) begin
                $error("replaced mismatch: expected %b, got %b", w.replaced, i_replaced);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            follow_left = '0;
            cp_accum    = '0;
            chars_expected.delete();
        end else begin
            // The block registers every result, so a word leaving now
            // never belongs to the byte arriving on the same edge.
            if (i_out_valid && i_out_ready)
                check_char();
            if (i_in_valid && i_in_ready)
                decode_byte(i_byte_in);
        end
        o_pending    <= chars_expected.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: tb/tb_utf8_byte_stream_decoder_top.sv
// Testbench top for the UTF-8 byte stream decoder: stimulus, receiver stalls and verdict.
module tb_utf8_byte_stream_decoder_top
    import u8d_pkg::*;
();

    localparam int          TIMEOUT_UNITS = 800000;
    localparam int          LONG_HOLD     = 150;
    localparam int unsigned RDY_ALWAYS    = 0;
    localparam int unsigned RDY_MOSTLY    = 1;
    localparam int unsigned RDY_SELDOM    = 2;
    localparam int unsigned RDY_TOGGLE    = 3;

    logic            clk;
    logic            rst_n;
    logic [7:0]      byte_in;
    logic            in_valid;
    logic            in_ready;
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            out_valid;
    logic            out_ready;
    int              fail_count;
    int              pending;

    logic [7:0]      directed_bytes[$];
    int              bytes_sent;
    int              burst_left;
    bit              flood;
    bit              hold_done;

    utf8_byte_stream_decoder_top u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_byte_in    (byte_in),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .o_code_point (code_point),
        .o_replaced   (replaced),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready)
    );

    utf8_byte_stream_decoder_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_byte_in    (byte_in),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_code_point (code_point),
        .i_replaced   (replaced),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Offers one byte, opening a new burst after a random gap when the last one is spent.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (flood)
                gap = 0;
            if (gap != 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        byte_in  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Mostly well-formed characters with random content; some broken sequences and noise.
    task automatic send_char();
        int unsigned pick;
        int unsigned n_follow;
        logic [7:0]  lead;
        pick     = $urandom_range(0, 99);
        n_follow = 0;
        if (pick < 40) begin
            lead = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 127));
        end else if (pick < 55) begin
            lead     = 8'($urandom_range(8'hC0, 8'hDF));
            n_follow = 1;
        end else if (pick < 70) begin
            lead     = 8'($urandom_range(8'hE0, 8'hEF));
            n_follow = 2;
        end else if (pick < 85) begin
            lead     = 8'($urandom_range(8'hF0, 8'hFF));
            n_follow = 3;
        end else if (pick < 92) begin
            lead = 8'($urandom_range(8'h80, 8'hBF));
        end else begin
            lead = 8'($urandom);
        end
        send_byte(lead);
        repeat (n_follow)
            send_byte(($urandom_range(0, 6) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)});
    endtask

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        byte_in    = 8'h00;
        bytes_sent = 0;
        burst_left = 0;
        flood      = 1'b0;
        // End marker, ASCII limits, stray continuations, the two- and three-byte lead
        // ranges at their extremes, a zero and non-continuation bytes inside a
        // sequence, and the largest value that a 0xF8-0xFF lead allows.
        directed_bytes = '{8'h00, 8'h41, 8'h7F, 8'h80, 8'hBF, 8'hC0, 8'h80, 8'hDF, 8'hBF,
                           8'hE0, 8'h00, 8'h00, 8'hEF, 8'hFF, 8'hC0, 8'hF7, 8'h3F, 8'h7F,
                           8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        wait_drained();

        // The receiver holds off while bytes keep coming, so the queue fills.
        flood = 1'b1;
        while (bytes_sent < 320)
            send_char();
        flood = 1'b0;
        while (bytes_sent < 700)
            send_char();
        wait_drained();
        while (bytes_sent < 1320)
            send_char();
        wait_drained();
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int unsigned seg_len;
        int unsigned mode;
        out_ready = 1'b0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (flood && !hold_done) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                seg_len = $urandom_range(8, 100);
                mode    = $urandom_range(RDY_ALWAYS, RDY_TOGGLE);
                repeat (seg_len) begin
                    @(negedge clk);
                    case (mode)
                        RDY_ALWAYS: out_ready <= 1'b1;
                        RDY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                        RDY_SELDOM: out_ready <= ($urandom_range(0, 3) == 0);
                        default:    out_ready <= ~out_ready;
                    endcase
                end
            end
        end
    end

    initial begin
        #TIMEOUT_UNITS;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
